[hdl/ssi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and codes for the sorted set insert unit.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_CLEARED   = 2'd3
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_CLEAR  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic                      cmp_en;
        logic                      shift_en;
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

[hdl/ssi_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_cell
// One entry of the sorted row: holds a value, compares it against the
// broadcast key and takes its left neighbor's value (or the key) on insert.
// ----------------------------------------------------------------------------
module ssi_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssi_pkg::cell_ctrl_t                 ctrl,
    input  logic                                live,
    input  logic signed [ssi_pkg::VALUE_W-1:0]  prev_val,
    input  logic                                prev_lt,
    output logic signed [ssi_pkg::VALUE_W-1:0]  val,
    output logic                                lt,
    output logic                                eq,
    output logic                                bnd
);
    import ssi_pkg::*;

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic                      lt_reg;
    logic                      lt_next;
    logic                      eq_reg;
    logic                      eq_next;

    always_comb
    begin
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        val_next = val_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = live && (val_reg < ctrl.key);
            eq_next = live && (val_reg == ctrl.key);
        end
        if (ctrl.shift_en && !lt_reg)
        begin
            val_next = prev_lt ? ctrl.key : prev_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;
    assign bnd = prev_lt && !lt_reg;

endmodule

[hdl/sorted_set_insert_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_insert_unit
// Ascending set of distinct signed values held in a row of cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser
//  s_      | in  | [31:0] value                 | [0] mode
//  m_      | out | [7:0] position, [16:8] count | [1:0] status
//
//  Each word goes through accept, parallel compare in every cell, then
//  reduce and shift/insert in one step. The next word is accepted in the
//  cycle after the update. A stalled output holds the update step only.
//  rst_n empties the set; stored values need no clearing.
// ----------------------------------------------------------------------------
module sorted_set_insert_unit
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // position[7:0], entry_count[16:8], zero pad
    output logic [1:0]  m_tuser    // status
);
    import ssi_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t state_reg;
    state_t state_next;

    logic signed [VALUE_W-1:0] key_reg;
    logic                      mode_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [POS_W-1:0]          out_pos_reg;
    logic [POS_W-1:0]          out_pos_next;
    status_t                   out_status_reg;
    status_t                   out_status_next;
    logic [COUNT_W-1:0]        out_count_reg;
    logic [COUNT_W-1:0]        out_count_next;

    cell_ctrl_t                ctrl;
    logic signed [VALUE_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]       cell_lt;
    logic [CAPACITY-1:0]       cell_eq;
    logic [CAPACITY-1:0]       cell_bnd;
    logic [CAPACITY-1:0]       cell_live;

    logic                      accept;
    logic                      out_free;
    logic                      dup;
    logic                      full;
    logic                      do_ins;
    logic [IDX_W-1:0]          place;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign dup      = |cell_eq;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign do_ins   = (mode_reg == MODE_INSERT) && !dup && !full;

    always_comb
    begin
        place = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_bnd[i])
            begin
                place = place | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_live[i] = (count_reg > CNT_W'(i));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready        = 1'b0;
        ctrl.cmp_en     = 1'b0;
        ctrl.shift_en   = 1'b0;
        ctrl.key        = key_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_pos_next    = out_pos_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_CMP:
            begin
                ctrl.cmp_en = 1'b1;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = '0;
                    if (mode_reg == MODE_CLEAR)
                    begin
                        count_next      = '0;
                        out_status_next = STATUS_CLEARED;
                    end
                    else if (dup)
                    begin
                        out_status_next = STATUS_DUPLICATE;
                    end
                    else if (full)
                    begin
                        out_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.shift_en   = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        out_pos_next    = POS_W'(place);
                        out_status_next = STATUS_INSERTED;
                    end
                    out_count_next = COUNT_W'(count_next);
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        if (!do_ins)
        begin
            ctrl.shift_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= s_tdata;
            mode_reg <= s_tuser[0];
        end
        out_pos_reg    <= out_pos_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_val;
            logic                      left_lt;
            if (g == 0)
            begin : g_head
                assign left_val = key_reg;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_body
                assign left_val = cell_val[g-1];
                assign left_lt  = cell_lt[g-1];
            end
            ssi_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .live     (cell_live[g]),
                .prev_val (left_val),
                .prev_lt  (left_lt),
                .val      (cell_val[g]),
                .lt       (cell_lt[g]),
                .eq       (cell_eq[g]),
                .bnd      (cell_bnd[g])
            );
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - POS_W - COUNT_W){1'b0}}, out_count_reg, out_pos_reg};
    assign m_tuser  = out_status_reg;

endmodule

[verif/sorted_set_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_checker
// Watches both stream channels of the sorted set insert unit. Every word
// accepted on the input side is run through a local model of the ascending
// set, and the outcome is queued. Every word accepted on the output side is
// compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module sorted_set_checker
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [0:0]  s_tuser,   // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // position[7:0], entry_count[16:8], zero pad
    input  logic [1:0]  m_tuser,   // status
    output int          mismatches,
    output int          outstanding
);
    import ssi_pkg::*;

    typedef struct {
        logic [POS_W-1:0]   position;
        status_t            status;
        logic [COUNT_W-1:0] entry_count;
    } outcome_t;

    logic signed [VALUE_W-1:0] set_values [CAPACITY];
    int                        set_size = 0;
    outcome_t                  pending_outcomes [$];
    int                        miss_total = 0;

    function automatic outcome_t place_in_set(input mode_t mode,
                                              input logic signed [VALUE_W-1:0] v);
        outcome_t o;
        int       slot;
        bit       hit;
        o.position = '0;
        slot       = 0;
        hit        = 1'b0;
        if (mode == MODE_CLEAR)
        begin
            set_size = 0;
            o.status = STATUS_CLEARED;
        end
        else
        begin
            for (int i = 0; i < set_size; i++)
            begin
                if (set_values[i] == v)
                    hit = 1'b1;
                else if (set_values[i] < v)
                    slot++;
            end
            if (hit)
                o.status = STATUS_DUPLICATE;
            else if (set_size >= CAPACITY)
                o.status = STATUS_FULL;
            else
            begin
                for (int i = set_size; i > slot; i--)
                    set_values[i] = set_values[i-1];
                set_values[slot] = v;
                set_size++;
                o.position = POS_W'(slot);
                o.status   = STATUS_INSERTED;
            end
        end
        o.entry_count = COUNT_W'(set_size);
        return o;
    endfunction

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    if (miss_total < 10)
                        $display("%0t: unexpected word pos=%0d status=%0d count=%0d",
                                 $realtime, m_tdata[7:0], m_tuser, m_tdata[16:8]);
                    miss_total++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (m_tdata[7:0] !== want.position || m_tuser !== want.status ||
                        m_tdata[16:8] !== want.entry_count)
                    begin
                        if (miss_total < 10)
                            $display({"%0t: mismatch exp pos=%0d status=%0d count=%0d,",
                                      " got pos=%0d status=%0d count=%0d"},
                                     $realtime, want.position, want.status,
                                     want.entry_count, m_tdata[7:0], m_tuser,
                                     m_tdata[16:8]);
                        miss_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_outcomes.push_back(place_in_set(mode_t'(s_tuser[0]),
                                                        $signed(s_tdata)));
        end
        outstanding <= pending_outcomes.size();
        mismatches  <= miss_total;
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sorted set insert unit: a directed pass over empty, full,
// duplicate and clear cases and the value extremes, then random runs of
// mostly inserts that each start from a clear, with bursts of idle cycles on both
// channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import ssi_pkg::*;

    localparam int SET_CAP = 16;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value
    logic [0:0]  s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // position[7:0], entry_count[16:8], zero pad
    logic [1:0]  m_tuser;   // status

    int mismatches;
    int outstanding;
    int words_sent;
    int send_idle;
    int recv_idle;
    int stall_left = 0;

    sorted_set_insert_unit #(.CAPACITY(SET_CAP)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sorted_set_checker #(.CAPACITY(SET_CAP)) chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // output stalls
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (recv_idle != 0 && $urandom_range(0, 99) < recv_idle)
        begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic push_word(input mode_t mode, input logic [31:0] v);
        int gap;
        if (send_idle != 0 && $urandom_range(0, 99) < send_idle)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // often a narrow band around zero so that duplicates are common
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'($urandom_range(0, 16)) - 32'd8;
            4:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            5:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
            6:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int    seq_len;
        int    wait_cycles;
        mode_t mode;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        words_sent = 0;
        send_idle  = 20;
        recv_idle  = 20;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        push_word(MODE_CLEAR, 32'h5A5A_A5A5);
        push_word(MODE_INSERT, 32'h0000_0000);
        push_word(MODE_INSERT, 32'h7FFF_FFFF);
        push_word(MODE_INSERT, 32'h8000_0000);
        push_word(MODE_INSERT, 32'hFFFF_FFFF);
        push_word(MODE_INSERT, 32'hFFFF_FFFF);
        push_word(MODE_INSERT, 32'h0000_0001);
        for (int k = 0; k < 11; k++)
            push_word(MODE_INSERT, (k % 2) ? -32'((k + 2) * 1000) : 32'((k + 2) * 1000));
        push_word(MODE_INSERT, 32'h0000_0002);
        push_word(MODE_INSERT, 32'h8000_0000);
        push_word(MODE_CLEAR, 32'hA5A5_5A5A);

        // random runs, each starting from an empty set
        while (words_sent < 1650)
        begin
            seq_len = $urandom_range(1, 24);
            if (words_sent >= 1450)
            begin
                send_idle = 0;
                recv_idle <= 0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                send_idle = 0;
                recv_idle <= 0;
            end
            else
            begin
                send_idle = $urandom_range(5, 40);
                recv_idle <= $urandom_range(5, 40);
            end
            push_word(MODE_CLEAR, $urandom);
            for (int k = 0; k < seq_len; k++)
            begin
                mode = ($urandom_range(0, 15) == 0) ? MODE_CLEAR : MODE_INSERT;
                push_word(mode, pick_value());
            end
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
